>>> hdl/jkf_pkg.sv
`default_nettype none

package jkf_pkg;

  localparam int KEY_MAX_BYTES_DEF = 16;
  localparam int DEPTH_BITS_DEF    = 8;
  localparam int POSITION_BITS_DEF = 32;

  localparam int KEY_REG_W   = 64;
  localparam int KEY_LEN_W   = 5;
  localparam int CFG_INDEX_W = 2;
  localparam int BYTE_W      = 8;
  localparam int STR_COUNT_W = 5;
  localparam int STATUS_W    = 3;
  localparam int VALUE_POS_W = 32;

  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_LOW  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_HIGH = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_LEN  = 2'd2;

  localparam logic [BYTE_W-1:0] CH_LBRACE    = 8'h7B;
  localparam logic [BYTE_W-1:0] CH_LBRACKET  = 8'h5B;
  localparam logic [BYTE_W-1:0] CH_RBRACE    = 8'h7D;
  localparam logic [BYTE_W-1:0] CH_RBRACKET  = 8'h5D;
  localparam logic [BYTE_W-1:0] CH_COLON     = 8'h3A;
  localparam logic [BYTE_W-1:0] CH_QUOTE     = 8'h22;
  localparam logic [BYTE_W-1:0] CH_BACKSLASH = 8'h5C;
  localparam logic [BYTE_W-1:0] CH_SPACE     = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TAB       = 8'h09;
  localparam logic [BYTE_W-1:0] CH_LF        = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR        = 8'h0D;

  typedef enum logic [2:0] {
    MODE_OUT,
    MODE_STR,
    MODE_ESC,
    MODE_AFTER_KEY,
    MODE_AFTER_COLON,
    MODE_DONE
  } jkf_mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_SCAN      = 3'd0,
    ST_VALUE     = 3'd1,
    ST_VALUE_END = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_IGNORE    = 3'd4
  } jkf_status_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              first_byte;
    logic              last_byte;
  } jkf_item_t;

  typedef struct packed {
    jkf_status_t             scan_status;
    logic [VALUE_POS_W-1:0]  value_position;
  } jkf_result_t;

  function automatic logic is_ws(input logic [BYTE_W-1:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
  endfunction

endpackage

`default_nettype wire

>>> hdl/jkf_scan_core.sv
`default_nettype none

module jkf_scan_core
  import jkf_pkg::*;
#(
  parameter int KEY_MAX_BYTES = KEY_MAX_BYTES_DEF,
  parameter int DEPTH_BITS    = DEPTH_BITS_DEF,
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 advance,
  input  wire jkf_item_t            item,
  input  wire logic [2*KEY_REG_W-1:0] key_flat,
  input  wire logic [KEY_LEN_W-1:0] key_length,
  output jkf_result_t               result
);

  jkf_mode_t                mode, mode_next, mode_e, mode_step;
  logic [DEPTH_BITS-1:0]    depth, depth_next, depth_e;
  logic [STR_COUNT_W-1:0]   count, count_next, count_e;
  logic                     match, match_next, match_e;
  logic [POSITION_BITS-1:0] pos, pos_next, pos_e, pos_inc;

  logic [BYTE_W-1:0] c;
  logic              ws;
  logic              is_open, is_close, close_fail;
  logic [BYTE_W-1:0] key_byte;
  logic              byte_miss;
  logic [STR_COUNT_W-1:0] count_inc;
  logic [DEPTH_BITS-1:0]  depth_open;
  jkf_status_t       status;
  logic [POSITION_BITS-1:0] vpos;

  // state seen by this byte, restarted on the first byte of a document
  always_comb begin
    if (item.first_byte) begin
      mode_e  = MODE_OUT;
      depth_e = '0;
      count_e = '0;
      match_e = 1'b1;
      pos_e   = '0;
    end else begin
      mode_e  = mode;
      depth_e = depth;
      count_e = count;
      match_e = match;
      pos_e   = pos;
    end
  end

  assign c          = item.data_byte;
  assign ws         = is_ws(c);
  assign is_open    = (c == CH_LBRACE) || (c == CH_LBRACKET);
  assign is_close   = (c == CH_RBRACE) || (c == CH_RBRACKET);
  assign close_fail = is_close && (depth_e <= DEPTH_BITS'(1));
  assign pos_inc    = (&pos_e) ? pos_e : pos_e + POSITION_BITS'(1);
  assign count_inc  = (&count_e) ? count_e : count_e + STR_COUNT_W'(1);
  assign depth_open = (&depth_e) ? depth_e : depth_e + DEPTH_BITS'(1);
  assign key_byte   = BYTE_W'(key_flat >> {count_e[3:0], 3'b000});
  assign byte_miss  = (count_e >= key_length) ||
                      (count_e >= STR_COUNT_W'(KEY_MAX_BYTES)) ||
                      (key_byte != c);

  // next state
  always_comb begin
    mode_step  = mode_e;
    depth_next = depth_e;
    count_next = count_e;
    match_next = match_e;
    pos_next   = pos_e;
    if (mode_e != MODE_DONE) begin
      pos_next = pos_inc;
      unique case (mode_e)
        MODE_STR: begin
          if (c == CH_QUOTE) begin
            if (depth_e == DEPTH_BITS'(1) && match_e && count_e == key_length) begin
              mode_step = MODE_AFTER_KEY;
            end else begin
              mode_step = MODE_OUT;
            end
          end else begin
            count_next = count_inc;
            match_next = match_e && !byte_miss;
            mode_step  = (c == CH_BACKSLASH) ? MODE_ESC : MODE_STR;
          end
        end
        MODE_ESC: begin
          count_next = count_inc;
          match_next = match_e && !byte_miss;
          mode_step  = MODE_STR;
        end
        MODE_AFTER_COLON: begin
          mode_step = MODE_AFTER_COLON;
        end
        default: begin
          // after key: colon or whitespace keep the match, anything else scans as outside
          if (mode_e == MODE_AFTER_KEY && c == CH_COLON) begin
            mode_step = MODE_AFTER_COLON;
          end else if (mode_e == MODE_AFTER_KEY && ws) begin
            mode_step = MODE_AFTER_KEY;
          end else begin
            mode_step = MODE_OUT;
            if (c == CH_QUOTE) begin
              mode_step  = MODE_STR;
              count_next = '0;
              match_next = 1'b1;
            end else if (is_open) begin
              depth_next = depth_open;
            end else if (is_close && !close_fail) begin
              depth_next = depth_e - DEPTH_BITS'(1);
            end
          end
        end
      endcase
    end
  end

  assign mode_next = (status != ST_SCAN) ? MODE_DONE : mode_step;

  // result of this byte
  always_comb begin
    status = ST_SCAN;
    vpos   = '0;
    unique case (mode_e)
      MODE_DONE: begin
        status = ST_IGNORE;
      end
      MODE_STR, MODE_ESC: begin
        status = ST_SCAN;
      end
      MODE_AFTER_KEY: begin
        if (c != CH_COLON && !ws && close_fail) begin
          status = ST_NOT_FOUND;
        end
      end
      MODE_AFTER_COLON: begin
        if (!ws) begin
          status = ST_VALUE;
          vpos   = pos_e;
        end
      end
      default: begin
        if (close_fail) begin
          status = ST_NOT_FOUND;
        end
      end
    endcase
    if (status == ST_SCAN && item.last_byte) begin
      if (mode_step == MODE_AFTER_COLON) begin
        status = ST_VALUE_END;
        vpos   = pos_inc;
      end else begin
        status = ST_NOT_FOUND;
      end
    end
  end

  assign result.scan_status    = status;
  assign result.value_position = VALUE_POS_W'(vpos);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_OUT;
      depth <= '0;
      count <= '0;
      match <= 1'b1;
      pos   <= '0;
    end else if (advance) begin
      mode  <= mode_next;
      depth <= depth_next;
      count <= count_next;
      match <= match_next;
      pos   <= pos_next;
    end
  end

endmodule

`default_nettype wire

>>> hdl/json_top_level_key_finder.sv
`default_nettype none

// channel   dir  tdata                 tuser                tlast
// s_*       in   [7:0] data_byte       [0] first_byte       last_byte
// m_*       out  [31:0] value_position [2:0] scan_status    -
// cfg_*     in   index 0 key low, 1 key high, 2 key length
//
// one request per cycle sustained while m_tready stays high; each byte is held in the input
// register and its result in the output register
// the scan state loop (mode, depth, string count, match flag, position) closes through combinational next-state logic
// synchronous reset clears the scan state, the key registers and both valid flags
// a stall on m_tready backs up through the input register to s_tready

module json_top_level_key_finder
  import jkf_pkg::*;
#(
  parameter int KEY_MAX_BYTES = KEY_MAX_BYTES_DEF,
  parameter int DEPTH_BITS    = DEPTH_BITS_DEF,
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [BYTE_W-1:0]      s_tdata,   // data_byte
  input  wire logic                   s_tuser,   // first_byte
  input  wire logic                   s_tlast,   // last_byte
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [VALUE_POS_W-1:0]      m_tdata,   // value_position
  output logic [STATUS_W-1:0]         m_tuser,   // scan_status
  input  wire logic                   cfg_wr_en,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [KEY_REG_W-1:0]   cfg_wr_data
);

  logic [KEY_REG_W-1:0] key_low, key_high;
  logic [KEY_LEN_W-1:0] key_length;

  logic        in_valid;
  jkf_item_t   in_item;
  logic        advance;
  jkf_result_t core_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_low    <= '0;
      key_high   <= '0;
      key_length <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_KEY_LOW:  key_low    <= cfg_wr_data;
        CFG_KEY_HIGH: key_high   <= cfg_wr_data;
        CFG_KEY_LEN:  key_length <= cfg_wr_data[KEY_LEN_W-1:0];
        default:      ;
      endcase
    end
  end

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.data_byte  <= s_tdata;
      in_item.first_byte <= s_tuser;
      in_item.last_byte  <= s_tlast;
    end
  end

  jkf_scan_core #(
    .KEY_MAX_BYTES (KEY_MAX_BYTES),
    .DEPTH_BITS    (DEPTH_BITS),
    .POSITION_BITS (POSITION_BITS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .item       (in_item),
    .key_flat   ({key_high, key_low}),
    .key_length (key_length),
    .result     (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= core_result.value_position;
      m_tuser <= core_result.scan_status;
    end
  end

endmodule

`default_nettype wire

>>> hdl/jkf_checker.sv
`default_nettype none

module jkf_checker
  import jkf_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   s_tready,
  input wire logic                   m_tvalid,
  input wire logic                   m_tready,
  input wire logic [VALUE_POS_W-1:0] m_tdata,
  input wire logic [STATUS_W-1:0]    m_tuser
);

  // held result stays put while the sink stalls
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed under stall");

  // no position with statuses that carry none
  a_pos_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == ST_SCAN || m_tuser == ST_NOT_FOUND || m_tuser == ST_IGNORE)
    |-> m_tdata == '0)
    else $error("position set without a value status");

  // a ready sink never blocks the source
  a_flow: assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready)
    else $error("source stalled while sink ready");

  // a found value closes the document: an ST_VALUE result is never handed over straight after another ST_VALUE
  a_done: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && (m_tuser == ST_VALUE || m_tuser == ST_VALUE_END)
    ##1 m_tvalid && m_tready && $past(m_tuser) == ST_VALUE && $stable(m_tuser)
    |-> 1'b0)
    else $error("two values in one document back to back");

  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind json_top_level_key_finder jkf_checker u_jkf_checker (.*);

`default_nettype wire

>>> bench/json_top_level_key_finder_tb.sv
`default_nettype none

module json_top_level_key_finder_tb;
  import jkf_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int MAX_PRINTED = 100;
  localparam logic [DEPTH_BITS_DEF-1:0] DEPTH_MAX = '1;
  localparam logic [VALUE_POS_W-1:0] POS_MAX = '1;
  localparam logic [STR_COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [BYTE_W-1:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [VALUE_POS_W-1:0] m_tdata;
  logic [STATUS_W-1:0] m_tuser;
  logic cfg_wr_en = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [KEY_REG_W-1:0] cfg_wr_data = '0;

  json_top_level_key_finder dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow of the key registers
  logic [KEY_REG_W-1:0] key_low = '0;
  logic [KEY_REG_W-1:0] key_high = '0;
  logic [KEY_LEN_W-1:0] key_len = '0;

  // shadow of the scan state
  jkf_mode_t mode = MODE_OUT;
  logic [DEPTH_BITS_DEF-1:0] depth = '0;
  logic [STR_COUNT_W-1:0] str_count = '0;
  logic str_match = 1'b1;
  logic [VALUE_POS_W-1:0] next_pos = '0;

  jkf_result_t pending_results[$];
  logic [BYTE_W-1:0] doc[$];
  int send_idle_pct = 37;
  int recv_idle_pct = 65;
  int sent_items = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  function automatic logic [BYTE_W-1:0] key_char(input int i);
    if (i < 8) return key_low[i*8 +: 8];
    return key_high[(i-8)*8 +: 8];
  endfunction

  function automatic logic is_blank(input logic [BYTE_W-1:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
  endfunction

  function automatic void string_byte(input logic [BYTE_W-1:0] c);
    if (str_count >= key_len || str_count >= KEY_MAX_BYTES_DEF ||
        key_char(int'(str_count)) != c)
      str_match = 1'b0;
    if (str_count != COUNT_MAX) str_count = str_count + STR_COUNT_W'(1);
  endfunction

  function automatic jkf_status_t outside_byte(input logic [BYTE_W-1:0] c);
    if (c == CH_QUOTE) begin
      mode = MODE_STR;
      str_count = '0;
      str_match = 1'b1;
    end else if (c == CH_LBRACE || c == CH_LBRACKET) begin
      if (depth != DEPTH_MAX) depth = depth + DEPTH_BITS_DEF'(1);
    end else if (c == CH_RBRACE || c == CH_RBRACKET) begin
      if (depth <= 1) return ST_NOT_FOUND;
      depth = depth - DEPTH_BITS_DEF'(1);
    end
    return ST_SCAN;
  endfunction

  function automatic jkf_result_t scan_step(input logic [BYTE_W-1:0] c, input logic first,
                                            input logic last);
    jkf_result_t r;
    logic [VALUE_POS_W-1:0] here;
    r.scan_status = ST_SCAN;
    r.value_position = '0;
    if (first) begin
      mode = MODE_OUT;
      depth = '0;
      str_count = '0;
      str_match = 1'b1;
      next_pos = '0;
    end
    if (mode == MODE_DONE) begin
      r.scan_status = ST_IGNORE;
      return r;
    end
    here = next_pos;
    if (next_pos != POS_MAX) next_pos = next_pos + VALUE_POS_W'(1);
    case (mode)
      MODE_STR: begin
        if (c == CH_QUOTE) begin
          if (depth == 1 && str_match && str_count == key_len) mode = MODE_AFTER_KEY;
          else mode = MODE_OUT;
        end else begin
          string_byte(c);
          if (c == CH_BACKSLASH) mode = MODE_ESC;
        end
      end
      MODE_ESC: begin
        string_byte(c);
        mode = MODE_STR;
      end
      MODE_AFTER_KEY: begin
        if (c == CH_COLON) begin
          mode = MODE_AFTER_COLON;
        end else if (!is_blank(c)) begin
          mode = MODE_OUT;
          r.scan_status = outside_byte(c);
        end
      end
      MODE_AFTER_COLON: begin
        if (!is_blank(c)) begin
          r.scan_status = ST_VALUE;
          r.value_position = here;
        end
      end
      default: begin
        mode = MODE_OUT;
        r.scan_status = outside_byte(c);
      end
    endcase
    if (r.scan_status == ST_SCAN && last) begin
      if (mode == MODE_AFTER_COLON) begin
        r.scan_status = ST_VALUE_END;
        r.value_position = (here != POS_MAX) ? here + VALUE_POS_W'(1) : here;
      end else begin
        r.scan_status = ST_NOT_FOUND;
      end
    end
    if (r.scan_status != ST_SCAN) mode = MODE_DONE;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTED)
      $display("mismatch %0s: got %0h, expected %0h", what, got, want);
  endtask

  // result checker and receiver side stalls
  always @(posedge clk) begin : check_results
    jkf_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", 64'(m_tuser), 64'(0));
      end else begin
        want = pending_results.pop_front();
        if (m_tuser !== want.scan_status)
          report_mismatch("scan_status", 64'(m_tuser), 64'(want.scan_status));
        if (m_tdata !== want.value_position)
          report_mismatch("value_position", 64'(m_tdata), 64'(want.value_position));
      end
    end
    if (!rst && ((s_tvalid && s_tready) || (m_tvalid && m_tready))) quiet_cycles = 0;
    else quiet_cycles++;
    m_tready <= (recv_idle_pct == 0) || ($urandom_range(0, 99) >= recv_idle_pct);
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic send_item(input logic [BYTE_W-1:0] b, input logic first, input logic last);
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tuser <= first;
    s_tlast <= last;
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(scan_step(b, first, last));
    sent_items++;
  endtask

  task automatic send_doc(input bit mark_first, input bit mark_last);
    for (int i = 0; i < doc.size(); i++)
      send_item(doc[i], mark_first && i == 0, mark_last && i == doc.size() - 1);
  endtask

  task automatic send_text(input string s, input bit mark_first, input bit mark_last);
    doc.delete();
    for (int i = 0; i < s.len(); i++) doc.push_back(s[i]);
    send_doc(mark_first, mark_last);
  endtask

  // wait until the block has handed back every pending result
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_key(input logic [KEY_REG_W-1:0] lo, input logic [KEY_REG_W-1:0] hi,
                             input logic [KEY_REG_W-1:0] len_word);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_KEY_LOW;
    cfg_wr_data <= lo;
    @(posedge clk);
    cfg_index <= CFG_KEY_HIGH;
    cfg_wr_data <= hi;
    @(posedge clk);
    cfg_index <= CFG_KEY_LEN;
    cfg_wr_data <= len_word;
    @(posedge clk);
    cfg_index <= CFG_UNUSED;
    cfg_wr_data <= {$urandom, $urandom};
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    key_low = lo;
    key_high = hi;
    key_len = len_word[KEY_LEN_W-1:0];
  endtask

  function automatic logic [BYTE_W-1:0] plain_char();
    logic [BYTE_W-1:0] c;
    if ($urandom_range(0, 2) != 0) return BYTE_W'(32'h61 + $urandom_range(0, 3));
    do c = BYTE_W'($urandom); while (c == CH_QUOTE || c == CH_BACKSLASH);
    return c;
  endfunction

  function automatic void put_blank(input int max_n);
    repeat ($urandom_range(0, max_n)) begin
      case ($urandom_range(0, 3))
        0: doc.push_back(CH_SPACE);
        1: doc.push_back(CH_TAB);
        2: doc.push_back(CH_LF);
        default: doc.push_back(CH_CR);
      endcase
    end
  endfunction

  function automatic void put_key_string();
    int n;
    int kind;
    int flip;
    n = int'(key_len);
    kind = $urandom_range(0, 9);
    flip = (n > 0) ? $urandom_range(0, n - 1) : 0;
    doc.push_back(CH_QUOTE);
    if (kind <= 7) begin
      if (kind == 6 && n > 0) n--;
      for (int i = 0; i < n; i++) begin
        if (kind == 5 && i == flip && i < KEY_MAX_BYTES_DEF)
          doc.push_back(key_char(i) ^ 8'h01);
        else doc.push_back(i < KEY_MAX_BYTES_DEF ? key_char(i) : plain_char());
      end
      if (kind == 7) doc.push_back(plain_char());
    end else begin
      repeat ($urandom_range(0, 6)) begin
        if ($urandom_range(0, 4) == 0) begin
          doc.push_back(CH_BACKSLASH);
          doc.push_back(BYTE_W'($urandom));
        end else begin
          doc.push_back(plain_char());
        end
      end
    end
    doc.push_back(CH_QUOTE);
  endfunction

  function automatic void put_value(input int lvl);
    int n;
    case ($urandom_range(0, lvl >= 3 ? 2 : 5))
      0: begin
        if ($urandom_range(0, 3) == 0) doc.push_back("-");
        repeat ($urandom_range(1, 3)) doc.push_back(BYTE_W'(32'h30 + $urandom_range(0, 9)));
      end
      1: begin
        doc.push_back(CH_QUOTE);
        repeat ($urandom_range(0, 3)) doc.push_back(plain_char());
        doc.push_back(CH_QUOTE);
      end
      2: begin
        doc.push_back("t");
        doc.push_back("r");
        doc.push_back("u");
        doc.push_back("e");
      end
      4: begin
        doc.push_back(CH_LBRACKET);
        n = $urandom_range(0, 2);
        for (int i = 0; i < n; i++) begin
          if (i != 0) doc.push_back(",");
          put_value(lvl + 1);
        end
        doc.push_back(CH_RBRACKET);
      end
      default: begin
        doc.push_back(CH_LBRACE);
        n = $urandom_range(0, 2);
        for (int i = 0; i < n; i++) begin
          if (i != 0) doc.push_back(",");
          put_member(lvl + 1);
        end
        doc.push_back(CH_RBRACE);
      end
    endcase
  endfunction

  function automatic void put_member(input int lvl);
    put_blank(1);
    put_key_string();
    put_blank(2);
    doc.push_back(CH_COLON);
    put_blank(2);
    put_value(lvl);
  endfunction

  function automatic void gen_document();
    int n;
    doc.delete();
    put_blank(1);
    doc.push_back($urandom_range(0, 7) == 0 ? CH_LBRACKET : CH_LBRACE);
    n = $urandom_range(0, 3);
    for (int i = 0; i < n; i++) begin
      if (i != 0) doc.push_back(",");
      put_member(1);
    end
    put_blank(1);
    doc.push_back(CH_RBRACE);
  endfunction

  task automatic choose_key(input int phase);
    logic [BYTE_W-1:0] kb[KEY_MAX_BYTES_DEF];
    logic [KEY_REG_W-1:0] lo;
    logic [KEY_REG_W-1:0] hi;
    logic [KEY_REG_W-1:0] len_word;
    int n;
    int i;
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 31) : $urandom_range(0, 16);
    if (phase == 3) n = 31;
    for (i = 0; i < KEY_MAX_BYTES_DEF; i++) kb[i] = BYTE_W'($urandom);
    i = 0;
    while (i < n && i < KEY_MAX_BYTES_DEF) begin
      if (i + 1 < n && i + 1 < KEY_MAX_BYTES_DEF && $urandom_range(0, 5) == 0) begin
        kb[i] = CH_BACKSLASH;
        kb[i+1] = BYTE_W'($urandom);
        i += 2;
      end else begin
        kb[i] = plain_char();
        i++;
      end
    end
    for (i = 0; i < 8; i++) begin
      lo[i*8 +: 8] = kb[i];
      hi[i*8 +: 8] = kb[i+8];
    end
    case (phase)
      0: begin
        lo = '0;
        hi = '0;
        n = 0;
      end
      1: begin
        lo = '1;
        hi = '1;
        n = KEY_MAX_BYTES_DEF;
      end
      2: begin
        lo = '0;
        hi = '0;
        n = KEY_MAX_BYTES_DEF;
      end
      default: ;
    endcase
    len_word = {$urandom, $urandom};
    len_word[KEY_LEN_W-1:0] = KEY_LEN_W'(n);
    program_key(lo, hi, len_word);
  endtask

  task automatic test_directed_cases();
    send_idle_pct = 37;
    recv_idle_pct = 65;
    settle();
    program_key(KEY_REG_W'("ba"), '0, KEY_REG_W'(2));
    send_text("{\"ab\": 1", 1, 0);
    // after a result the block ignores bytes until a new document
    send_item(8'hFF, 1'b0, 1'b0);
    send_item(8'h00, 1'b1, 1'b1);
    send_text("{\"ab\":", 1, 1);
    send_text("]", 1, 1);
    send_text("{\"a\\", 1, 1);
    send_text("{\"ab\"x", 1, 1);
    settle();
  endtask

  task automatic test_nesting_saturation();
    doc.delete();
    repeat (300) doc.push_back(CH_LBRACE);
    repeat (256) doc.push_back(CH_RBRACE);
    send_doc(1, 1);
    settle();
  endtask

  task automatic test_random_documents(input int send_pct, input int recv_pct,
                                       input int target);
    int start;
    int phase_start;
    int phase;
    int pick;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    start = sent_items;
    phase = 0;
    while (sent_items - start < target) begin
      settle();
      choose_key(phase);
      phase++;
      phase_start = sent_items;
      while (sent_items - phase_start < 30 && sent_items - start < target) begin
        if ($urandom_range(0, 7) == 0) begin
          repeat ($urandom_range(1, 12))
            send_item(BYTE_W'($urandom), $urandom_range(0, 15) == 0,
                      $urandom_range(0, 7) == 0);
        end else begin
          gen_document();
          pick = $urandom_range(0, 9);
          if (pick == 0) begin
            doc = doc[0 : $urandom_range(0, doc.size() - 1)];
          end else if (pick == 1) begin
            doc[$urandom_range(0, doc.size() - 1)] = BYTE_W'($urandom);
          end else if (pick == 2) begin
            doc.insert($urandom_range(0, doc.size()), BYTE_W'($urandom));
          end
          send_doc($urandom_range(0, 9) != 0, $urandom_range(0, 4) != 0);
        end
      end
    end
    settle();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_nesting_saturation();
    test_random_documents(37, 65, 160);
    test_random_documents(65, 37, 160);
    test_random_documents(0, 0, 160);
    settle();
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
hdl/jkf_pkg.sv
hdl/jkf_scan_core.sv
hdl/json_top_level_key_finder.sv
hdl/jkf_checker.sv
bench/json_top_level_key_finder_tb.sv
